@@ design/u8d_pkg.sv @@
// shared types and constants of the utf-8 decoder
`default_nettype none

package u8d_pkg;

  // unit counter width default
  localparam int unsigned COUNT_BITS_DEF = 16;

  // field widths fixed by the interface
  localparam int unsigned CODE_W  = 21;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CAP_W   = 16;

  // run queue depth
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam logic REG_OUT_MODE     = 1'b0;
  localparam logic REG_OUT_CAPACITY = 1'b1;

  // surrogate construction
  localparam logic [CODE_W-1:0] SUPP_BASE    = 21'h10000;
  localparam logic [15:0]       SURR_HI_BASE = 16'hD800;
  localparam logic [15:0]       SURR_LO_BASE = 16'hDC00;

  // halt and status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_CAPACITY  = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_t;

  // all results caused by one input item
  typedef struct packed {
    logic [1:0]        n_units;
    logic              has_status;
    logic [CODE_W-1:0] code0;
    logic [CNT_W-1:0]  count0;
    logic [CODE_W-1:0] code1;
    logic [CNT_W-1:0]  count1;
    status_t           stat;
    logic [CNT_W-1:0]  count_st;
  } run_t;

endpackage

`default_nettype wire

@@ design/utf8_to_utf16_utf32_decoder.sv @@
// top level of the utf-8 to utf-16 / utf-32 decoder
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | data_byte, end_of_text
//  out_    | output    | out_valid/out_stall| code_unit, is_status, status,
//          |           |                    | unit_count, last_of_run
//  cfg_    | input     | cfg_wr_en          | cfg_index, cfg_wdata
//
// one byte is accepted per cycle while the run queue has room; the front end
// decodes in the same cycle. each result is a separate output item, so a byte
// that yields a surrogate pair and a status item holds the back end for three
// results. a byte's results are registered in the run queue before they are
// presented. reset clears decoder state, queue and configuration; in_stall
// rises only when the four-entry run queue is full.
`default_nettype none

module utf8_to_utf16_utf32_decoder #(
  parameter int unsigned COUNT_BITS = u8d_pkg::COUNT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic                       cfg_index,
  input  wire logic [u8d_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 in_data_byte,
  input  wire logic                       in_end_of_text,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [u8d_pkg::CODE_W-1:0]      out_code_unit,
  output logic                            out_is_status,
  output logic [1:0]                      out_status,
  output logic [u8d_pkg::CNT_W-1:0]       out_unit_count,
  output logic                            out_last_of_run
);
  import u8d_pkg::*;

  logic              mode_r;
  logic [CAP_W-1:0]  capacity_r;
  logic              q_push, q_full, q_pop, q_empty;
  run_t              q_entry, q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      capacity_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_OUT_MODE:     mode_r     <= cfg_wdata[0];
        REG_OUT_CAPACITY: capacity_r <= cfg_wdata[CAP_W-1:0];
        default:          ;
      endcase
    end
  end

  u8d_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .mode          (mode_r),
    .capacity      (capacity_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_end_of_text(in_end_of_text),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  u8d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  u8d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .empty          (q_empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_unit  (out_code_unit),
    .out_is_status  (out_is_status),
    .out_status     (out_status),
    .out_unit_count (out_unit_count),
    .out_last_of_run(out_last_of_run)
  );

endmodule

`default_nettype wire

@@ design/u8d_front.sv @@
// front end: takes bytes, tracks sequence state and builds at most one run per byte
`default_nettype none

module u8d_front #(
  parameter int unsigned COUNT_BITS = u8d_pkg::COUNT_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      mode,
  input  wire logic [u8d_pkg::CAP_W-1:0] capacity,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [7:0]                in_data_byte,
  input  wire logic                      in_end_of_text,
  input  wire logic                      q_full,
  output logic                           q_push,
  output u8d_pkg::run_t                  q_entry
);
  import u8d_pkg::*;

  localparam int unsigned WIDE = (COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [1:0]            pend_r, pend_nxt;
  logic [CODE_W-1:0]     acc_r, acc_nxt;
  logic [COUNT_BITS-1:0] units_r, units_nxt;
  status_t               halt_r, halt_nxt;

  logic                  accept;
  logic                  complete;
  logic                  pair;
  logic [CODE_W-1:0]     cp;
  logic [CODE_W-1:0]     acc_shift;
  logic [19:0]           supp_off;
  logic [COUNT_BITS-1:0] u1, u2;
  logic [WIDE:0]         need_sum;
  logic [WIDE-1:0]       u1_wide, u2_wide;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // saturating counts after one and two more units
  assign u1 = (units_r == COUNT_MAX) ? units_r : units_r + 1'b1;
  assign u2 = (u1 == COUNT_MAX) ? u1 : u1 + 1'b1;

  assign acc_shift = {acc_r[CODE_W-7:0], in_data_byte[5:0]};
  assign supp_off  = 20'(cp - SUPP_BASE);

  // decode one byte
  always_comb begin
    pend_nxt  = pend_r;
    acc_nxt   = acc_r;
    units_nxt = units_r;
    halt_nxt  = halt_r;
    complete  = 1'b0;
    cp        = '0;
    pair      = 1'b0;
    need_sum  = '0;
    q_entry   = '0;
    if (halt_r == ST_OK) begin
      if (pend_r == 2'd0) begin
        if (!in_data_byte[7]) begin
          complete = 1'b1;
          cp       = CODE_W'(in_data_byte);
        end else if (in_data_byte[7:5] == 3'b110) begin
          acc_nxt  = CODE_W'(in_data_byte[4:0]);
          pend_nxt = 2'd1;
        end else if (in_data_byte[7:4] == 4'b1110) begin
          acc_nxt  = CODE_W'(in_data_byte[3:0]);
          pend_nxt = 2'd2;
        end else if (in_data_byte[7:3] == 5'b11110) begin
          acc_nxt  = CODE_W'(in_data_byte[2:0]);
          pend_nxt = 2'd3;
        end else begin
          halt_nxt = ST_INVALID;
        end
      end else begin
        acc_nxt  = acc_shift;
        pend_nxt = pend_r - 2'd1;
        if (pend_r == 2'd1) begin
          complete = 1'b1;
          cp       = acc_shift;
        end
      end
      // emit the finished code point against the capacity
      if (complete) begin
        pair     = mode && (cp[CODE_W-1:16] != '0);
        need_sum = (WIDE+1)'(units_r) + (pair ? (WIDE+1)'(2) : (WIDE+1)'(1));
        if ((capacity != '0) && (need_sum > (WIDE+1)'(capacity))) begin
          halt_nxt = ST_CAPACITY;
        end else begin
          units_nxt = pair ? u2 : u1;
          if (capacity != '0) begin
            q_entry.n_units = pair ? 2'd2 : 2'd1;
          end
        end
      end
      if (in_end_of_text && (halt_nxt == ST_OK) && (pend_nxt != 2'd0)) begin
        halt_nxt = ST_TRUNCATED;
      end
    end
    q_entry.code0    = pair ? CODE_W'(SURR_HI_BASE | 16'(supp_off[19:10])) : cp;
    q_entry.code1    = CODE_W'(SURR_LO_BASE | 16'(supp_off[9:0]));
    q_entry.count0   = u1_wide[CNT_W-1:0];
    q_entry.count1   = u2_wide[CNT_W-1:0];
    q_entry.stat     = halt_nxt;
    // final count includes any unit made by this byte
    q_entry.count_st = CNT_W'(units_nxt);
    // end of text closes the run with a status item and clears state
    if (in_end_of_text) begin
      q_entry.has_status = 1'b1;
      pend_nxt  = '0;
      acc_nxt   = '0;
      units_nxt = '0;
      halt_nxt  = ST_OK;
    end
  end

  assign u1_wide  = WIDE'(u1);
  assign u2_wide  = WIDE'(u2);
  assign q_push   = accept && ((q_entry.n_units != 2'd0) || in_end_of_text);

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      acc_r   <= '0;
      units_r <= '0;
      halt_r  <= ST_OK;
    end else if (accept) begin
      pend_r  <= pend_nxt;
      acc_r   <= acc_nxt;
      units_r <= units_nxt;
      halt_r  <= halt_nxt;
    end
  end

  // once halted, only an end of text brings the decoder back
  property p_halt_sticky;
    @(posedge clk) disable iff (!rst_n)
      (halt_r != ST_OK) && !(accept && in_end_of_text) |=> (halt_r == $past(halt_r));
  endproperty
  a_halt_sticky: assert property (p_halt_sticky) else $error("halt code changed while halted");

  // a halted decoder queues no units
  property p_no_units_halted;
    @(posedge clk) disable iff (!rst_n)
      (halt_r != ST_OK) |-> (q_entry.n_units == 2'd0);
  endproperty
  a_no_units_halted: assert property (p_no_units_halted) else $error("units while halted");

endmodule

`default_nettype wire

@@ design/u8d_queue.sv @@
// short run queue between the front end and the back end
`default_nettype none

module u8d_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  u8d_pkg::run_t      push_entry,
  output logic               full,
  input  wire logic          pop,
  output u8d_pkg::run_t      head,
  output logic               empty
);
  import u8d_pkg::*;

  run_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slots[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // no overflow and no underflow
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("push into full run queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
    else $error("pop from empty run queue");

endmodule

`default_nettype wire

@@ design/u8d_back.sv @@
// back end: walks the head run and presents its results one per cycle while out_stall is low
`default_nettype none

module u8d_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  u8d_pkg::run_t                   head,
  input  wire logic                       empty,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [u8d_pkg::CODE_W-1:0]      out_code_unit,
  output logic                            out_is_status,
  output logic [1:0]                      out_status,
  output logic [u8d_pkg::CNT_W-1:0]       out_unit_count,
  output logic                            out_last_of_run
);
  import u8d_pkg::*;

  logic [1:0] sel_r;
  logic [1:0] total;
  logic       is_unit;
  logic       out_take;

  assign total     = head.n_units + 2'(head.has_status);
  assign is_unit   = (sel_r < head.n_units);
  assign out_valid = !empty;
  assign out_take  = out_valid && !out_stall;
  assign out_last_of_run = (sel_r == total - 2'd1);
  assign pop       = out_take && out_last_of_run;

  // pick the result at the current position of the run
  always_comb begin
    out_code_unit  = '0;
    out_is_status  = 1'b0;
    out_status     = ST_OK;
    out_unit_count = head.count_st;
    if (is_unit) begin
      out_code_unit  = sel_r[0] ? head.code1 : head.code0;
      out_unit_count = sel_r[0] ? head.count1 : head.count0;
    end else begin
      out_is_status = 1'b1;
      out_status    = head.stat;
    end
  end

  // position within the run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= '0;
    end else if (out_take) begin
      sel_r <= out_last_of_run ? 2'd0 : sel_r + 2'd1;
    end
  end

  // position stays inside the head run
  a_sel_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (sel_r < total))
    else $error("result position beyond run");

endmodule

`default_nettype wire

@@ bench/tb_utf8_to_utf16_utf32_decoder.sv @@
// testbench of the utf-8 to utf-16 / utf-32 decoder with a self-checking decode predictor
`default_nettype none

module tb_utf8_to_utf16_utf32_decoder;
  import u8d_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 80;
  localparam int RANDOM_BYTES = 210;

  // one expected result of the decoder
  typedef struct {
    logic [CODE_W-1:0] code;
    logic              is_stat;
    status_t           stat;
    logic [CNT_W-1:0]  count;
    logic              last;
  } decoded_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic                 cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           in_data_byte;
  logic                 in_end_of_text;
  logic                 out_valid;
  logic                 out_stall;
  logic [CODE_W-1:0]    out_code_unit;
  logic                 out_is_status;
  logic [1:0]           out_status;
  logic [CNT_W-1:0]     out_unit_count;
  logic                 out_last_of_run;

  // decode predictor state and its copy of the registers
  logic                 mode_utf16;
  logic [CAP_W-1:0]     unit_cap;
  logic [1:0]           cont_left;
  logic [CODE_W-1:0]    code_acc;
  logic [CNT_W-1:0]     units_out;
  status_t              halt_state;

  decoded_t             decoded_q[$];
  int                   mismatches;
  int                   results_seen;
  int                   bytes_sent;
  int                   cycles;
  int                   hold_left;
  bit                   tx_calm;
  bit                   rx_calm;

  utf8_to_utf16_utf32_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_unit   (out_code_unit),
    .out_is_status   (out_is_status),
    .out_status      (out_status),
    .out_unit_count  (out_unit_count),
    .out_last_of_run (out_last_of_run)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver stalls: forced hold-off first, then random unless calm
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (rx_calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 32);
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin : result_check
    decoded_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (decoded_q.size() == 0) begin
        $error("result with nothing expected: code_unit %0h is_status %0b",
               out_code_unit, out_is_status);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (out_code_unit !== want.code) begin
          $error("code_unit: expected %0h, got %0h", want.code, out_code_unit);
          mismatches++;
        end
        if (out_is_status !== want.is_stat) begin
          $error("is_status: expected %0b, got %0b", want.is_stat, out_is_status);
          mismatches++;
        end
        if (out_status !== want.stat) begin
          $error("status: expected %0d, got %0d", want.stat, out_status);
          mismatches++;
        end
        if (out_unit_count !== want.count) begin
          $error("unit_count: expected %0d, got %0d", want.count, out_unit_count);
          mismatches++;
        end
        if (out_last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, out_last_of_run);
          mismatches++;
        end
      end
    end
  end

  // predictor helpers
  task automatic push_result(input logic [CODE_W-1:0] code, input logic is_stat,
                             input status_t stat);
    decoded_t r;
    r.code    = code;
    r.is_stat = is_stat;
    r.stat    = stat;
    r.count   = units_out;
    r.last    = 1'b0;
    decoded_q.push_back(r);
  endtask

  task automatic count_unit();
    if (units_out != {CNT_W{1'b1}})
      units_out++;
  endtask

  // finished code point: one unit, a surrogate pair, or a capacity halt
  task automatic emit_code_point(input logic [CODE_W-1:0] cp);
    logic        pair;
    logic [16:0] need;
    logic [CODE_W-1:0] off;
    pair = mode_utf16 && (cp > 21'h00FFFF);
    need = pair ? 17'd2 : 17'd1;
    off  = cp - SUPP_BASE;
    if (unit_cap != '0 && {1'b0, units_out} + need > {1'b0, unit_cap}) begin
      halt_state = ST_CAPACITY;
    end else if (!pair) begin
      count_unit();
      if (unit_cap != '0)
        push_result(cp, 1'b0, ST_OK);
    end else begin
      count_unit();
      if (unit_cap != '0)
        push_result({5'd0, SURR_HI_BASE | {6'd0, off[19:10]}}, 1'b0, ST_OK);
      count_unit();
      if (unit_cap != '0)
        push_result({5'd0, SURR_LO_BASE | {6'd0, off[9:0]}}, 1'b0, ST_OK);
    end
  endtask

  // expected results of one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic eot);
    int base;
    base = decoded_q.size();
    if (halt_state == ST_OK) begin
      if (cont_left == 2'd0) begin
        if (!b[7]) begin
          emit_code_point({13'd0, b});
        end else if (b[7:5] == 3'b110) begin
          code_acc  = {16'd0, b[4:0]};
          cont_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          code_acc  = {17'd0, b[3:0]};
          cont_left = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          code_acc  = {18'd0, b[2:0]};
          cont_left = 2'd3;
        end else begin
          halt_state = ST_INVALID;
        end
      end else begin
        // tag bits of a continuation are not checked
        code_acc  = {code_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0)
          emit_code_point(code_acc);
      end
      if (eot && halt_state == ST_OK && cont_left != 2'd0)
        halt_state = ST_TRUNCATED;
    end
    if (eot) begin
      push_result('0, 1'b1, halt_state);
      cont_left  = 2'd0;
      code_acc   = '0;
      units_out  = '0;
      halt_state = ST_OK;
    end
    if (decoded_q.size() > base)
      decoded_q[decoded_q.size()-1].last = 1'b1;
  endtask

  // send one item, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = 0;
    while (!tx_calm && $urandom_range(99) < 32)
      gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    decode_byte(b, eot);
    bytes_sent++;
  endtask

  task automatic cfg_write(input logic idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_OUT_MODE)
      mode_utf16 = val[0];
    else
      unit_cap = val[CAP_W-1:0];
  endtask

  // drop valid, wait for all results and let the block go idle
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_seq(input logic [7:0] seq[$], input logic eot_at_end);
    foreach (seq[k])
      send_byte(seq[k], eot_at_end && (k == seq.size() - 1));
  endtask

  // well-formed text with random content, some stray bytes and cut endings
  task automatic send_text(input int n_cp);
    logic [7:0] text_q[$];
    logic [7:0] r;
    int         ncont;
    for (int i = 0; i < n_cp; i++) begin
      r     = 8'($urandom);
      ncont = 0;
      case ($urandom_range(9))
        0, 1, 2, 3: text_q.push_back({1'b0, r[6:0]});
        4, 5: begin
          text_q.push_back({3'b110, r[4:0]});
          ncont = 1;
        end
        6, 7: begin
          text_q.push_back({4'b1110, r[3:0]});
          ncont = 2;
        end
        8: begin
          text_q.push_back({5'b11110, r[2:0]});
          ncont = 3;
        end
        default: text_q.push_back(r);
      endcase
      repeat (ncont) begin
        r = 8'($urandom);
        text_q.push_back(($urandom_range(9) == 0) ? r : {2'b10, r[5:0]});
      end
    end
    if (text_q.size() > 1 && $urandom_range(7) == 0)
      void'(text_q.pop_back());
    send_seq(text_q, 1'b1);
  endtask

  task automatic pick_config();
    logic [CFG_W-1:0] cap_pick;
    case ($urandom_range(5))
      0:       cap_pick = '0;
      1:       cap_pick = 16'hFFFF;
      2:       cap_pick = 16'd1;
      3, 4:    cap_pick = CFG_W'($urandom_range(12, 2));
      default: cap_pick = CFG_W'($urandom);
    endcase
    cfg_write(REG_OUT_MODE, CFG_W'($urandom_range(1)));
    cfg_write(REG_OUT_CAPACITY, cap_pick);
  endtask

  // utf-32 extremes, unchecked continuation and the largest code point
  task automatic test_utf32_extremes();
    cfg_write(REG_OUT_MODE, 16'd0);
    cfg_write(REG_OUT_CAPACITY, 16'hFFFF);
    send_seq('{8'h00, 8'h7F, 8'hC3, 8'h7F, 8'hF7, 8'hBF, 8'hBF, 8'hBF}, 1'b1);
    settle();
  endtask

  // utf-16 top of the basic plane and the top surrogate pair
  task automatic test_utf16_pairs();
    cfg_write(REG_OUT_MODE, 16'd1);
    send_seq('{8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1'b1);
    settle();
  endtask

  // invalid lead bytes, ignored bytes after a halt, text cut short
  task automatic test_halts();
    send_seq('{8'h80, 8'h41}, 1'b1);
    send_seq('{8'hFF}, 1'b1);
    send_seq('{8'hE2, 8'h82}, 1'b1);
    settle();
  endtask

  // a pair that does not fit the capacity, then count-only mode
  task automatic test_capacity();
    cfg_write(REG_OUT_CAPACITY, 16'd3);
    send_seq('{8'h41, 8'h42, 8'hF0, 8'h9F, 8'h98, 8'h80}, 1'b1);
    settle();
    cfg_write(REG_OUT_CAPACITY, 16'd0);
    send_seq('{8'h41, 8'hC3, 8'hA9}, 1'b1);
    settle();
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    cfg_write(REG_OUT_MODE, 16'd1);
    cfg_write(REG_OUT_CAPACITY, 16'hFFFF);
    hold_left = HOLD_CYCLES;
    tx_calm   = 1'b1;
    repeat (6) send_seq('{8'hF0, 8'h9F, 8'h98, 8'h80, 8'h5A}, 1'b0);
    send_byte(8'h2E, 1'b1);
    tx_calm = 1'b0;
    settle();
  endtask

  // random texts under changing settings
  task automatic test_random_texts(input int n_bytes);
    int start;
    start = bytes_sent;
    settle();
    pick_config();
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(3) == 0) begin
        settle();
        pick_config();
      end
      send_text($urandom_range(10, 1));
    end
    settle();
  endtask

  // a stretch with no idling on either side
  task automatic test_back_to_back();
    cfg_write(REG_OUT_MODE, 16'd1);
    cfg_write(REG_OUT_CAPACITY, 16'hFFFF);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    repeat (4) send_text(8);
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    settle();
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_data_byte   = 8'h00;
    in_end_of_text = 1'b0;
    out_stall      = 1'b0;
    hold_left      = 0;
    tx_calm        = 1'b0;
    rx_calm        = 1'b0;
    mismatches     = 0;
    results_seen   = 0;
    bytes_sent     = 0;
    mode_utf16     = 1'b0;
    unit_cap       = '0;
    cont_left      = 2'd0;
    code_acc       = '0;
    units_out      = '0;
    halt_state     = ST_OK;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_utf32_extremes();
    test_utf16_pairs();
    test_halts();
    test_capacity();
    test_backpressure();
    test_back_to_back();
    test_random_texts(RANDOM_BYTES);

    $display("decoded %0d bytes into %0d checked results", bytes_sent, results_seen);
    $display("both output modes, capacity halts, invalid and cut texts, hold-off");
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
